/* rtl/core/kst_pkg.sv */
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types, codes and key tables for the scan-code translator.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int unsigned QUEUE_DEPTH = 128;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned KEY_COUNT   = 58;
  localparam int unsigned KEY_IDX_W   = $clog2(KEY_COUNT);

  localparam logic [CODE_W-1:0] CODE_CAPS       = 8'h3A;
  localparam logic [CODE_W-1:0] CODE_SHIFT_DOWN = 8'h2A;
  localparam logic [CODE_W-1:0] CODE_SHIFT_UP   = 8'hAA;
  localparam logic [CODE_W-1:0] CODE_LAST_KEY   = 8'h39;

  typedef enum logic {
    ACT_SCAN = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic  push;
    char_t ch;
  } push_req_t;

  // Unshifted key map, letters in lower case
  localparam char_t KEY_BASE [KEY_COUNT] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
    7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
    7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
    7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  // Shifted key map, letters in upper case
  localparam char_t KEY_SHIFT [KEY_COUNT] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
    7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
    7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
    7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

endpackage

/* rtl/core/kst_if.sv */
// ----------------------------------------------------------------------------
// kst_req_if / kst_rsp_if
// Valid/ready channels for requests into and results out of the translator.
// ----------------------------------------------------------------------------
interface kst_req_if;
  import kst_pkg::*;

  logic  valid;
  logic  ready;
  logic  action;
  code_t scan_code;

  modport source (output valid, output action, output scan_code, input ready);
  modport sink   (input valid, input action, input scan_code, output ready);
endinterface

interface kst_rsp_if;
  import kst_pkg::*;

  logic  valid;
  logic  ready;
  char_t character;
  logic  was_empty;

  modport source (output valid, output character, output was_empty, input ready);
  modport sink   (input valid, input character, input was_empty, output ready);
endinterface

/* rtl/core/kst_ram.sv */
// ----------------------------------------------------------------------------
// kst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/kst_xlate.sv */
// ----------------------------------------------------------------------------
// kst_xlate
// Modifier flags and scan-code to ASCII lookup.
// ----------------------------------------------------------------------------
module kst_xlate (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              scan_vld_i,
  input  kst_pkg::code_t    code_i,
  output kst_pkg::push_req_t push_o
);
  import kst_pkg::*;

  logic                 caps_q, caps_d;
  logic                 shift_q, shift_d;
  logic                 is_key;
  logic                 is_letter;
  logic                 use_shift;
  logic [KEY_IDX_W-1:0] key_idx;

  always_comb begin
    caps_d  = caps_q;
    shift_d = shift_q;
    if (scan_vld_i) begin
      unique case (code_i)
        CODE_CAPS: begin
          caps_d = ~caps_q;
        end
        CODE_SHIFT_DOWN: begin
          shift_d = 1'b1;
        end
        CODE_SHIFT_UP: begin
          shift_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caps_q  <= 1'b0;
      shift_q <= 1'b0;
    end else begin
      caps_q  <= caps_d;
      shift_q <= shift_d;
    end
  end

  assign is_key  = (code_i <= CODE_LAST_KEY);
  assign key_idx = is_key ? code_i[KEY_IDX_W-1:0] : '0;

  // Letter rows: caps lock flips the case, symbols follow shift alone
  assign is_letter = ((code_i >= 8'h10) && (code_i <= 8'h19)) ||
                     ((code_i >= 8'h1E) && (code_i <= 8'h26)) ||
                     ((code_i >= 8'h2C) && (code_i <= 8'h32));
  assign use_shift = is_letter ? (caps_d ^ shift_d) : shift_d;

  assign push_o.push = scan_vld_i && is_key;
  assign push_o.ch   = use_shift ? KEY_SHIFT[key_idx] : KEY_BASE[key_idx];

endmodule

/* rtl/core/kst_fifo.sv */
// ----------------------------------------------------------------------------
// kst_fifo
// Character queue: head/tail pointers, fill count and the backing RAM.
// ----------------------------------------------------------------------------
module kst_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kst_pkg::push_req_t push_i,
  input  logic               pop_i,
  output logic               empty_o,
  output kst_pkg::char_t     rd_data_o
);
  import kst_pkg::*;

  ptr_t head_q, head_d;
  ptr_t tail_q, tail_d;
  cnt_t count_q, count_d;
  logic full;
  logic wr_en;

  assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  // drop the push when the queue is full
  assign wr_en   = push_i.push && !full;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (wr_en) begin
      tail_d  = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
    if (pop_i) begin
      head_d  = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  kst_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tail_q),
    .wdata_i (push_i.ch),
    .re_i    (pop_i),
    .raddr_i (head_q),
    .rdata_o (rd_data_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(wr_en && pop_i))
    else $error("push and pop in the same cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (count_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with mismatched pointers");

endmodule

/* rtl/core/keyboard_scancode_translator.sv */
// ----------------------------------------------------------------------------
// keyboard_scancode_translator
// Scan-code set 1 to ASCII translator with a character queue.
// ----------------------------------------------------------------------------
// Requests arrive on req_i: action 0 carries a scan-code byte, action 1
// asks for one queued character. Scan codes update the caps lock and shift
// flags and push the translated character; they return nothing on rsp_o.
// Each read request returns exactly one result on rsp_o: the character, or
// character 0 with was_empty set when the queue holds nothing.
// A request is registered in the input register on acceptance and is
// processed from there; when a read leaves it, the queue RAM's registered
// read and the result register load together, and the read result is
// then offered on rsp_o. One request is taken per cycle while req_i.ready
// is high. A scan code never waits in the input register; a read waits
// there only while a previous result is held on rsp_o, and requests
// behind it wait on req_i.
// Reset clears the flags and empties the queue at once; the RAM itself is
// not cleared and needs no sweep. When the receiver stalls, the result
// holds on rsp_o and req_i keeps taking requests until a read meets it.
// ----------------------------------------------------------------------------
module keyboard_scancode_translator (
  input  logic      clk_i,
  input  logic      rst_ni,
  kst_req_if.sink   req_i,
  kst_rsp_if.source rsp_o
);
  import kst_pkg::*;

  logic      s1_valid_q;
  action_e   s1_action_q;
  code_t     s1_code_q;
  logic      s1_go;
  logic      s1_read;
  logic      s2_valid_q;
  logic      s2_empty_q;
  logic      fifo_empty;
  logic      pop;
  char_t     rd_data;
  push_req_t push_req;

  assign s1_read = s1_valid_q && (s1_action_q == ACT_READ);
  // a read advances only when the result stage is free or draining
  assign s1_go   = s1_valid_q && (!s1_read || !s2_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_go;
  assign pop     = s1_read && s1_go && !fifo_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_action_q <= action_e'(req_i.action);
      s1_code_q   <= req_i.scan_code;
    end
  end

  kst_xlate u_xlate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .scan_vld_i (s1_valid_q && (s1_action_q == ACT_SCAN)),
    .code_i     (s1_code_q),
    .push_o     (push_req)
  );

  kst_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_req),
    .pop_i     (pop),
    .empty_o   (fifo_empty),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_read && s1_go) begin
      s2_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_read && s1_go) begin
      s2_empty_q <= fifo_empty;
    end
  end

  assign rsp_o.valid     = s2_valid_q;
  assign rsp_o.was_empty = s2_empty_q;
  assign rsp_o.character = s2_empty_q ? '0 : rd_data;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (s1_read && s1_go && fifo_empty) |=> (s2_valid_q && s2_empty_q))
    else $error("empty read did not report empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   pop |=> (s2_valid_q && !s2_empty_q))
    else $error("pop did not produce a character result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (s1_valid_q && !s1_go) |-> (s1_read && s2_valid_q && !rsp_o.ready))
    else $error("request held without a stalled result");

endmodule
